/* design/md5_pkg.sv */
// Shared constants, types and helpers for the MD5 message digest block.
// Holds the round constants, rotate amounts and the core control structs.
// No dependencies; compiled before every other design file.
package md5_pkg;

  localparam int WORD_W = 32;
  localparam int LEN_W  = 61;

  // Initial chaining values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Padding marker byte
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Per-round additive constants
  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {quarter, round mod 4}
  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // Control from the sequencer to the compression core
  typedef struct packed {
    logic start;  // load working words and begin 64 rounds
    logic init;   // reload chaining words with the initial values
  } core_ctl_t;

  // Status from the compression core
  typedef struct packed {
    logic        done;   // chaining words updated this cycle
    logic [31:0] word_d;
    logic [31:0] word_c;
    logic [31:0] word_b;
    logic [31:0] word_a;
  } core_sts_t;

  function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
    logic [3:0] idx;
    idx = {rnd[5:4], rnd[1:0]};
    return ROT_TABLE[idx];
  endfunction

  // Message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] m;
    logic [3:0] g;
    m = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    g = m;
      2'd1:    g = 4'((m << 2) + m + 4'd1);
      2'd2:    g = 4'((m << 1) + m + 4'd5);
      default: g = 4'((m << 3) - m);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

endpackage

/* design/md5_if.sv */
// Handshake interfaces for the MD5 block: byte input and digest output.
// Depends on nothing; compiled after md5_pkg.
interface md5_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       has_byte;
  logic       last_byte;

  modport source (output valid, output message_byte, output has_byte,
                  output last_byte, input ready);
  modport sink   (input valid, input message_byte, input has_byte,
                  input last_byte, output ready);
endinterface

interface md5_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_ab;
  logic [63:0] digest_cd;

  modport source (output valid, output digest_ab, output digest_cd, input ready);
  modport sink   (input valid, input digest_ab, input digest_cd, output ready);
endinterface

/* design/md5_word_ram.sv */
// Sixteen-word block buffer with byte-lane write enables and registered read.
// Uses md5_pkg for the word width.
module md5_word_ram (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [3:0]                 wr_addr,
  input  logic [3:0]                 wr_be,
  input  logic [md5_pkg::WORD_W-1:0] wr_data,
  input  logic [3:0]                 rd_addr,
  output logic [md5_pkg::WORD_W-1:0] rd_data
);

  logic [md5_pkg::WORD_W-1:0] mem [16];

  // Byte-lane write
  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (wr_en && wr_be[l]) begin
        mem[wr_addr][8*l +: 8] <= wr_data[8*l +: 8];
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* design/md5_core.sv */
// MD5 compression core: one round per cycle over words read from the block RAM.
// Holds the chaining words. Uses md5_pkg for constants, helpers and structs.
module md5_core (
  input  logic                 clk,
  input  logic                 rst,
  input  md5_pkg::core_ctl_t   ctl,
  input  logic [31:0]          rd_data,
  output logic [3:0]           rd_addr,
  output md5_pkg::core_sts_t   sts
);

  // cnt 0: first read issued; 1: first word in; 2: first pre-sum;
  // 3..66: rounds 0..63; 67: add into chaining words
  localparam logic [6:0] CNT_PRE   = 7'd2;
  localparam logic [6:0] CNT_RND0  = 7'd3;
  localparam logic [6:0] CNT_RNDN  = 7'd66;
  localparam logic [6:0] CNT_LAST  = 7'd67;

  logic        busy;
  logic [6:0]  cnt;
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [31:0] km;   // message word plus round constant
  logic [31:0] pre;  // a + km for the current round

  logic [5:0]  rnd;
  logic [5:0]  kidx;
  logic [31:0] f;
  logic [31:0] rot;
  logic        in_rounds;

  assign rnd       = 6'(cnt - CNT_RND0);
  assign kidx      = 6'(cnt - 7'd1);
  assign in_rounds = busy && (cnt >= CNT_RND0) && (cnt <= CNT_RNDN);
  assign rd_addr   = md5_pkg::msg_index(cnt[5:0]);

  // Round function
  always_comb begin
    unique case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    rot = md5_pkg::rotl(pre + f, md5_pkg::rot_amt(rnd));
  end

  // Sequencing and chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      chain[0] <= md5_pkg::IV_A;
      chain[1] <= md5_pkg::IV_B;
      chain[2] <= md5_pkg::IV_C;
      chain[3] <= md5_pkg::IV_D;
    end else begin
      if (ctl.init) begin
        chain[0] <= md5_pkg::IV_A;
        chain[1] <= md5_pkg::IV_B;
        chain[2] <= md5_pkg::IV_C;
        chain[3] <= md5_pkg::IV_D;
      end
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= 7'(cnt + 7'd1);
        if (cnt == CNT_LAST) begin
          busy     <= 1'b0;
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
        end
      end
    end
  end

  // Working words and the pre-sum pipeline
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (busy) begin
      km <= rd_data + md5_pkg::K_TABLE[kidx];
      if (cnt == CNT_PRE) begin
        pre <= a + km;
      end
      if (in_rounds) begin
        a   <= d;
        d   <= c;
        c   <= b;
        b   <= b + rot;
        pre <= d + km;
      end
    end
  end

  assign sts.done   = busy && (cnt == CNT_LAST);
  assign sts.word_a = chain[0];
  assign sts.word_b = chain[1];
  assign sts.word_c = chain[2];
  assign sts.word_d = chain[3];

endmodule

/* design/md5_message_digest.sv */
// MD5 message digest top level: byte intake, padding sequencer, output register.
// Depends on md5_pkg, md5_if (interfaces), md5_word_ram and md5_core.
//
// Usage:
//   msg carries one item per cycle while msg.ready is high: message_byte with
//   has_byte = 1 is a message byte; last_byte = 1 ends the message (with or without
//   a byte). An item with has_byte = 0 and last_byte = 0 is taken and ignored.
//   digest carries one item per message: digest_ab = {B, A}, digest_cd = {D, C}.
// Flow:
//   A byte that neither completes a 64-byte block nor ends the message leaves
//   msg.ready high; the byte that completes one holds msg.ready low while the
//   core runs one round per cycle, reading one message word per cycle from the
//   block RAM. Ending a message writes the marker word, then the words after it
//   (up to 15), and puts the bit length in words 14 and 15 of the last block,
//   which is a padding-only block when fewer than nine bytes remain after the data.
// Reset: clears the byte count, loads the initial chaining values, empties the
//   output register and holds msg.ready low; the block RAM is written before use.
// Stall: the digest is held in an output register; input bytes keep flowing
//   while it waits. A message ending while the previous digest is still unread
//   waits in the final state until that register drains.
module md5_message_digest (
  input  logic              clk,
  input  logic              rst,
  md5_byte_if.sink          msg,
  md5_digest_if.source      digest
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COMP = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_ZERO = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Which block the core is working on
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_SPILL = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  logic [2:0]                state;
  logic [1:0]                kind;
  logic                      pend_last;
  logic                      spill;
  logic [4:0]                wptr;
  logic [md5_pkg::LEN_W-1:0] len;
  logic                      out_valid;
  logic [63:0]               out_ab;
  logic [63:0]               out_cd;

  logic                      accept;
  logic                      fills_block;
  logic                      out_free;
  logic [63:0]               len_bits;

  logic                      wr_en;
  logic [3:0]                wr_addr;
  logic [3:0]                wr_be;
  logic [31:0]               wr_data;
  logic [3:0]                rd_addr;
  logic [31:0]               rd_data;

  md5_pkg::core_ctl_t        ctl;
  md5_pkg::core_sts_t        sts;

  assign msg.ready    = (state == S_IDLE) && !rst;
  assign accept       = msg.valid && msg.ready;
  assign fills_block  = msg.has_byte && (len[5:0] == 6'd63);
  assign out_free     = !out_valid || digest.ready;
  assign len_bits     = {len, 3'b000};

  assign digest.valid     = out_valid;
  assign digest.digest_ab = out_ab;
  assign digest.digest_cd = out_cd;

  // Block buffer writes and core control
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = len[5:2];
    wr_be      = 4'b0000;
    wr_data    = '0;
    ctl.start  = 1'b0;
    ctl.init   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && msg.has_byte) begin
          wr_en   = 1'b1;
          wr_be   = 4'b0001 << len[1:0];
          wr_data = {4{msg.message_byte}};
        end
        ctl.start = accept && fills_block;
      end
      S_MARK: begin
        // marker byte, zeros in the higher lanes of the same word
        wr_en   = 1'b1;
        wr_be   = 4'b1111 << len[1:0];
        wr_data = {24'h000000, md5_pkg::PAD_MARK} << {len[1:0], 3'b000};
      end
      S_ZERO: begin
        if (wptr[4]) begin
          ctl.start = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = wptr[3:0];
          wr_be   = 4'b1111;
          if (!spill && wptr[3:0] == 4'd14) begin
            wr_data = len_bits[31:0];
          end else if (!spill && wptr[3:0] == 4'd15) begin
            wr_data = len_bits[63:32];
          end
        end
      end
      S_COMP: begin
      end
      S_FIN: begin
        ctl.init = out_free;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= KIND_DATA;
      pend_last <= 1'b0;
      spill     <= 1'b0;
      wptr      <= '0;
      len       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (msg.has_byte) begin
              len <= md5_pkg::LEN_W'(len + 1'b1);
            end
            if (fills_block) begin
              state     <= S_COMP;
              kind      <= KIND_DATA;
              pend_last <= msg.last_byte;
            end else if (msg.last_byte) begin
              state <= S_MARK;
            end
          end
        end
        S_MARK: begin
          spill <= (len[5:0] >= 6'd56);
          wptr  <= 5'({1'b0, len[5:2]} + 5'd1);
          state <= S_ZERO;
        end
        S_ZERO: begin
          if (wptr[4]) begin
            state <= S_COMP;
            kind  <= spill ? KIND_SPILL : KIND_FINAL;
          end else begin
            wptr <= 5'(wptr + 5'd1);
          end
        end
        S_COMP: begin
          if (sts.done) begin
            unique case (kind)
              KIND_DATA:  state <= pend_last ? S_MARK : S_IDLE;
              KIND_SPILL: begin
                // padding-only block follows
                spill <= 1'b0;
                wptr  <= '0;
                state <= S_ZERO;
              end
              KIND_FINAL: state <= S_FIN;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            len   <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register valid: loaded from the final state, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (digest.valid && digest.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_ab <= {sts.word_b, sts.word_a};
      out_cd <= {sts.word_d, sts.word_c};
    end
  end

  md5_word_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_be   (wr_be),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  md5_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .sts     (sts)
  );

endmodule

/* design/md5_checker.sv */
// Port-level checks for md5_message_digest, attached by the bind below.
// Sees only the top level's ports; no package dependency.
module md5_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_ab,
  input logic [63:0] digest_cd
);

  // A stalled digest stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("digest item dropped while stalled");

  // A stalled digest keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(digest_ab) && $stable(digest_cd))
    else $error("digest changed while stalled");

  // Ending a message always makes the block busy, with the final data block or with padding
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after an end of message");

  // No digest is offered straight out of reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("digest item offered after reset");

  // A digest needs padding and a full block of rounds, so it never follows
  // an accepted end of message in the very next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last && !out_valid |=> !out_valid)
    else $error("digest offered too soon after end of message");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (msg.valid),
  .in_ready  (msg.ready),
  .in_last   (msg.last_byte),
  .out_valid (digest.valid),
  .out_ready (digest.ready),
  .digest_ab (digest.digest_ab),
  .digest_cd (digest.digest_cd)
);
